### rtl/nssb_pkg.sv
// Shared types, constants and helpers for the nearest-neighbor RGB565 blit core.
`default_nettype none

package nssb_pkg;

    // Command codes carried on the input tuser bit.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DST_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_DST_HEIGHT = 2'd3;

    // Register values after reset.
    localparam logic [8:0] RST_SRC_WIDTH  = 9'd320;
    localparam logic [7:0] RST_SRC_HEIGHT = 8'd240;
    localparam logic [9:0] RST_DST_WIDTH  = 10'd320;
    localparam logic [8:0] RST_DST_HEIGHT = 9'd240;

    // RGB565 packing: bits dropped per channel and field positions.
    localparam int unsigned RED_DROP   = 3;
    localparam int unsigned GREEN_DROP = 2;
    localparam int unsigned BLUE_DROP  = 3;
    localparam int unsigned RED_POS    = 11;
    localparam int unsigned GREEN_POS  = 5;

    // Numerator widths of the two scale divisions.
    localparam int unsigned NUMX_W = 19;
    localparam int unsigned NUMY_W = 17;

    // Queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef logic [NUMX_W-1:0] t_numx;
    typedef logic [NUMY_W-1:0] t_numy;
    typedef logic [18:0]       t_idx;

    // One classified work item as it travels through the queue.
    typedef struct packed {
        logic        is_read;
        logic        empty;
        logic [9:0]  x;
        logic [8:0]  y;
        logic [15:0] rgb;
    } t_item;

    // Configuration as seen by the back part; source sizes already clamped.
    typedef struct packed {
        logic [8:0] sw;
        logic [7:0] sh;
        logic [9:0] dst_w;
        logic [8:0] dst_h;
    } t_cfg;

    // Truncate an 8-bit-per-channel color to RGB565.
    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        pack565 = (16'(r >> RED_DROP) << RED_POS) | (16'(g >> GREEN_DROP) << GREEN_POS)
                | 16'(b >> BLUE_DROP);
    endfunction

endpackage

`default_nettype wire

### rtl/nssb_fifo.sv
// Short work-item queue that decouples the front classifier from the back engine.
`default_nettype none

module nssb_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire nssb_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_avail,
    output nssb_pkg::t_item      o_item
);

    localparam int unsigned DEPTH = nssb_pkg::QUEUE_DEPTH;
    localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    nssb_pkg::t_item r_slot [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_avail = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];

    // Pointer and fill bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("queue fill count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |-> !i_push) else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_avail |-> !i_pop) else $error("pop from an empty queue");

endmodule

`default_nettype wire

### rtl/nssb_front.sv
// Front part: configuration registers, input word classification and queue push.
`default_nettype none

module nssb_front #(
    parameter int unsigned SRC_MAX_W = 320,
    parameter int unsigned SRC_MAX_H = 240
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [9:0]      i_cfg_data,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [47:0]     i_in_data,
    input  wire logic            i_in_kind,
    input  wire logic            i_queue_full,
    output logic                 o_push,
    output nssb_pkg::t_item      o_item,
    output nssb_pkg::t_cfg       o_cfg
);

    logic [8:0] r_src_width;
    logic [7:0] r_src_height;
    logic [9:0] r_dst_width;
    logic [8:0] r_dst_height;

    logic [8:0] w_sw;
    logic [7:0] w_sh;
    logic [9:0] w_x;
    logic [8:0] w_y;
    logic       w_read;
    logic       w_keep;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= nssb_pkg::RST_SRC_WIDTH;
            r_src_height <= nssb_pkg::RST_SRC_HEIGHT;
            r_dst_width  <= nssb_pkg::RST_DST_WIDTH;
            r_dst_height <= nssb_pkg::RST_DST_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nssb_pkg::CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[8:0];
                nssb_pkg::CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[7:0];
                nssb_pkg::CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data;
                nssb_pkg::CFG_DST_HEIGHT: r_dst_height <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Source size in use never exceeds the frame store.
    assign w_sw = (32'(r_src_width) < 32'(SRC_MAX_W)) ? r_src_width : 9'(SRC_MAX_W);
    assign w_sh = (32'(r_src_height) < 32'(SRC_MAX_H)) ? r_src_height : 8'(SRC_MAX_H);

    assign o_cfg.sw    = w_sw;
    assign o_cfg.sh    = w_sh;
    assign o_cfg.dst_w = r_dst_width;
    assign o_cfg.dst_h = r_dst_height;

    // Classify: writes must land in the source, reads in the destination.
    assign w_x    = i_in_data[9:0];
    assign w_y    = i_in_data[18:10];
    assign w_read = (i_in_kind == nssb_pkg::CMD_READ);
    assign w_keep = w_read ? ((w_x < r_dst_width) && (w_y < r_dst_height))
                           : ((w_x < {1'b0, w_sw}) && (w_y < {1'b0, w_sh}));

    assign o_in_ready   = !i_queue_full;
    assign o_push       = i_in_valid && !i_queue_full && w_keep;
    assign o_item.is_read = w_read;
    assign o_item.empty   = (w_sw == '0) || (w_sh == '0);
    assign o_item.x       = w_x;
    assign o_item.y       = w_y;
    assign o_item.rgb     = nssb_pkg::pack565(i_in_data[26:19], i_in_data[34:27],
                                              i_in_data[42:35]);

endmodule

`default_nettype wire

### rtl/nssb_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module nssb_div #(
    parameter int unsigned NW = 19,
    parameter int unsigned DW = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_busy,
    output logic [NW-1:0]      o_quot
);

    localparam int unsigned CW = $clog2(NW + 1);

    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quot;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;

    logic [DW:0]   w_trial;
    logic          w_fit;

    // Bring down the next numerator bit and try the subtraction.
    assign w_trial = {r_rem, r_quot[NW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: remainder and the numerator that shifts into the quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= w_fit ? DW'(w_trial - {1'b0, r_den}) : w_trial[DW-1:0];
            r_quot <= {r_quot[NW-2:0], w_fit};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

### rtl/nssb_back.sv
// Back part: scale divisions, frame store access and the result output register.
`default_nettype none

module nssb_back #(
    parameter int unsigned SRC_MAX_W = 320,
    parameter int unsigned SRC_MAX_H = 240
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire nssb_pkg::t_cfg  i_cfg,
    input  wire logic            i_avail,
    input  wire nssb_pkg::t_item i_item,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [39:0]          o_out_data
);

    localparam int unsigned DEPTH = SRC_MAX_W * SRC_MAX_H;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_ADDR  = 7'b0001000,
        S_READ  = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    nssb_pkg::t_item  r_item;
    nssb_pkg::t_idx   r_idx;
    logic [AW-1:0]    r_addr;
    logic [15:0]      r_rdata;
    logic [15:0]      r_frame [DEPTH];
    logic             r_out_valid;
    logic [15:0]      r_out_pixel;
    nssb_pkg::t_idx   r_out_idx;

    logic             w_start;
    logic             w_busy_x;
    logic             w_busy_y;
    nssb_pkg::t_numx  w_qx;
    nssb_pkg::t_numy  w_qy;
    logic [9:0]       w_ax;
    logic [8:0]       w_ay;
    logic [31:0]      w_addr_full;
    logic             w_out_free;

    assign o_pop      = (r_state == S_IDLE) && i_avail;
    assign w_start    = (r_state == S_MUL);
    assign w_out_free = !r_out_valid || i_out_ready;

    // Column and row scale divisions run side by side.
    nssb_div #(.NW(nssb_pkg::NUMX_W), .DW(10)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (nssb_pkg::t_numx'(r_item.x) * nssb_pkg::t_numx'(i_cfg.sw)),
        .i_den   (i_cfg.dst_w),
        .o_busy  (w_busy_x),
        .o_quot  (w_qx)
    );

    nssb_div #(.NW(nssb_pkg::NUMY_W), .DW(9)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (nssb_pkg::t_numy'(r_item.y) * nssb_pkg::t_numy'(i_cfg.sh)),
        .i_den   (i_cfg.dst_h),
        .o_busy  (w_busy_y),
        .o_quot  (w_qy)
    );

    // Store address: scaled position for reads, item position for writes.
    assign w_ax        = r_item.is_read ? w_qx[9:0] : r_item.x;
    assign w_ay        = r_item.is_read ? w_qy[8:0] : r_item.y;
    assign w_addr_full = 32'(w_ay) * 32'(SRC_MAX_W) + 32'(w_ax);

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_avail) n_state = S_ADDR;
            S_MUL:   n_state = S_DIV;
            S_DIV:   if (!w_busy_x && !w_busy_y) n_state = S_ADDR;
            S_ADDR:  n_state = r_item.is_read ? S_READ : S_WRITE;
            S_READ:  n_state = S_OUT;
            S_WRITE: n_state = S_IDLE;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        // A popped read goes through the multiply and divide steps first.
        if (r_state == S_IDLE && i_avail && i_item.is_read) begin
            n_state = S_MUL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Item capture, destination index and store address.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (r_state == S_MUL) begin
            r_idx <= nssb_pkg::t_idx'(r_item.y) * nssb_pkg::t_idx'(i_cfg.dst_w)
                   + nssb_pkg::t_idx'(r_item.x);
        end
        if (r_state == S_ADDR) begin
            r_addr <= w_addr_full[AW-1:0];
        end
    end

    // Frame store: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_frame[r_addr] <= r_item.rgb;
        end
        if (r_state == S_READ) begin
            r_rdata <= r_frame[r_addr];
        end
    end

    // Output register, loaded when free or being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_out_pixel <= r_item.empty ? 16'd0 : r_rdata;
            r_out_idx   <= r_idx;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {5'd0, r_out_idx, r_out_pixel};

    a_quot_in_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADDR && r_item.is_read && !r_item.empty)
            |-> (w_qx < nssb_pkg::t_numx'(i_cfg.sw)) && (w_qy < nssb_pkg::t_numy'(i_cfg.sh)))
        else $error("scaled position outside the source frame");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADDR || r_state == S_READ || r_state == S_OUT)
            |-> (!w_busy_x && !w_busy_y))
        else $error("divider still busy after the division step");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not loaded into the output register");

endmodule

`default_nettype wire

### rtl/nearest_scale_rgb565_blit_core.sv
// Top level of the nearest-neighbor scaling RGB565 blit core.
//
// Input words arrive on the s_axis channel: tuser selects a source-pixel
// write or a scaled destination-pixel read, tdata carries position and color.
// Result words leave on the m_axis channel, one for each read that falls
// inside the destination; writes and out-of-range items give no word.
// Registers are written over the cfg channel, which is always ready. The
// user must write them only while the core holds no pending work; the core does not check it.
// A four-entry queue sits behind the input classifier, so input words are
// taken while the back engine works and while a result waits on m_axis.
// The back engine takes one item at a time. A read passes through the
// multiply step, the two restoring dividers (one quotient bit per cycle,
// over 19 and 17 bits), then the address, store read and output steps;
// a write passes through the address step, then the frame store write port.
// After reset the registers hold 320x240 source and 320x240 destination and
// the frame store contents are undefined until written.
// When m_axis stalls, the result is held in the output register, the engine
// stops before the next result and input is refused once the queue fills.
`default_nettype none

module nearest_scale_rgb565_blit_core #(
    parameter int unsigned SRC_MAX_W = 320,
    parameter int unsigned SRC_MAX_H = 240
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: pos_x[9:0], pos_y[18:10], red[26:19], green[34:27], blue[42:35], zero pad
    input  wire logic [47:0] s_axis_tdata,
    // tuser: cmd
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: pixel_rgb565[15:0], dst_index[34:16], zero pad
    output logic [39:0]      m_axis_tdata
);

    logic            w_full;
    logic            w_push;
    logic            w_pop;
    logic            w_avail;
    nssb_pkg::t_item w_push_item;
    nssb_pkg::t_item w_pop_item;
    nssb_pkg::t_cfg  w_cfg;

    nssb_front #(.SRC_MAX_W(SRC_MAX_W), .SRC_MAX_H(SRC_MAX_H)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_kind    (s_axis_tuser),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_item       (w_push_item),
        .o_cfg        (w_cfg)
    );

    nssb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_avail (w_avail),
        .o_item  (w_pop_item)
    );

    nssb_back #(.SRC_MAX_W(SRC_MAX_W), .SRC_MAX_H(SRC_MAX_H)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_avail     (w_avail),
        .i_item      (w_pop_item),
        .o_pop       (w_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for the nearest-neighbor scaling RGB565 blit core.
module tb_top;

    localparam int unsigned SRC_MAX_W     = 320;
    localparam int unsigned SRC_MAX_H     = 240;
    localparam int unsigned FRAME_DEPTH   = SRC_MAX_W * SRC_MAX_H;
    localparam int          TARGET_ITEMS  = 1300;
    localparam int          SETTLE_CYCLES = 150;
    localparam int          DRAIN_LIMIT   = 5000;
    localparam int          LONG_HOLD     = 300;
    localparam int          RUN_LIMIT     = 2000000;

    // One expected result word.
    typedef struct packed {
        logic [18:0] index;
        logic [15:0] rgb;
    } t_pixel_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [9:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    // Predictor state: source frame, which entries hold data, and the sizes.
    logic [15:0] frame_mem [FRAME_DEPTH];
    bit          frame_written [FRAME_DEPTH];
    logic [8:0]  cur_src_w;
    logic [7:0]  cur_src_h;
    logic [9:0]  cur_dst_w;
    logic [8:0]  cur_dst_h;

    t_pixel_word expected_pixels [$];
    int          mismatch_count;
    int          sent_items;
    bit          feed_steady;
    bit          sink_steady;
    bit          hold_request;

    nearest_scale_rgb565_blit_core #(
        .SRC_MAX_W(SRC_MAX_W),
        .SRC_MAX_H(SRC_MAX_H)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("nearest_scale_rgb565_blit_core verification failed");
        $finish;
    end

    // Source sizes as the core uses them, clamped to the store.
    function automatic int unsigned used_src_w();
        return (cur_src_w < SRC_MAX_W) ? cur_src_w : SRC_MAX_W;
    endfunction

    function automatic int unsigned used_src_h();
        return (cur_src_h < SRC_MAX_H) ? cur_src_h : SRC_MAX_H;
    endfunction

    // Update the frame copy for an accepted word and queue the result it causes.
    task automatic predict_blit(input logic cmd, input logic [9:0] x, input logic [8:0] y,
                                input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b);
        int unsigned sw, sh, xi, yi, dw, dh, addr;
        t_pixel_word want;
        sw = used_src_w();
        sh = used_src_h();
        xi = x;
        yi = y;
        dw = cur_dst_w;
        dh = cur_dst_h;
        if (cmd == nssb_pkg::CMD_WRITE) begin
            if (xi < sw && yi < sh) begin
                addr = yi * SRC_MAX_W + xi;
                frame_mem[addr] = {r[7:3], g[7:2], b[7:3]};
                frame_written[addr] = 1'b1;
            end
        end else if (xi < dw && yi < dh) begin
            want.rgb = 16'd0;
            if (sw != 0 && sh != 0)
                want.rgb = frame_mem[(yi * sh / dh) * SRC_MAX_W + xi * sw / dw];
            want.index = 19'(yi * dw + xi);
            expected_pixels.push_back(want);
        end
    endtask

    // Offer one input word and hold it until the core takes it.
    task automatic send_word(input logic cmd, input logic [9:0] x, input logic [8:0] y,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = feed_steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {5'd0, b, g, r, y, x};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predict_blit(cmd, x, y, r, g, b);
        sent_items++;
        @(negedge i_clk);
    endtask

    // Read a destination pixel; the source entry it selects is written first if empty.
    task automatic read_dst(input logic [9:0] x, input logic [8:0] y);
        int unsigned sw, sh, sx, sy;
        sw = used_src_w();
        sh = used_src_h();
        if (x < cur_dst_w && y < cur_dst_h && sw != 0 && sh != 0) begin
            sx = int'(x) * sw / cur_dst_w;
            sy = int'(y) * sh / cur_dst_h;
            if (!frame_written[sy * SRC_MAX_W + sx])
                send_word(nssb_pkg::CMD_WRITE, 10'(sx), 9'(sy), 8'($urandom), 8'($urandom),
                          8'($urandom));
        end
        send_word(nssb_pkg::CMD_READ, x, y, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Stop feeding, wait for every pending result, then let queued writes finish.
    task automatic settle_idle();
        t_pixel_word want;
        s_axis_tvalid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && expected_pixels.size() != 0; n++)
            @(negedge i_clk);
        while (expected_pixels.size() != 0) begin
            want = expected_pixels.pop_front();
            $display("%0t: missing result word: expected rgb=%h index=%0d, actual none",
                     $time, want.rgb, want.index);
            mismatch_count++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write all four size registers while the core is idle.
    task automatic set_sizes(input logic [8:0] sw, input logic [7:0] sh,
                             input logic [9:0] dw, input logic [8:0] dh);
        logic [1:0] reg_index [4];
        logic [9:0] reg_value [4];
        settle_idle();
        reg_index[0] = nssb_pkg::CFG_SRC_WIDTH;
        reg_index[1] = nssb_pkg::CFG_SRC_HEIGHT;
        reg_index[2] = nssb_pkg::CFG_DST_WIDTH;
        reg_index[3] = nssb_pkg::CFG_DST_HEIGHT;
        reg_value[0] = 10'(sw);
        reg_value[1] = 10'(sh);
        reg_value[2] = dw;
        reg_value[3] = 10'(dh);
        for (int i = 0; i < 4; i++) begin
            i_cfg_index <= reg_index[i];
            i_cfg_data  <= reg_value[i];
            i_cfg_valid <= 1'b1;
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            case (reg_index[i])
                nssb_pkg::CFG_SRC_WIDTH:  cur_src_w = reg_value[i][8:0];
                nssb_pkg::CFG_SRC_HEIGHT: cur_src_h = reg_value[i][7:0];
                nssb_pkg::CFG_DST_WIDTH:  cur_dst_w = reg_value[i];
                nssb_pkg::CFG_DST_HEIGHT: cur_dst_h = reg_value[i][8:0];
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Random size, mostly in the usual range, sometimes tiny or past it.
    function automatic int unsigned pick_size(input int unsigned usual,
                                              input int unsigned reg_max);
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 8);
            3:       return $urandom_range(usual, reg_max);
            default: return $urandom_range(1, usual);
        endcase
    endfunction

    // Mixed traffic: in-range writes and reads, full-range noise and boundary words.
    task automatic random_items(input int count);
        int          kind;
        int unsigned sw, sh;
        for (int i = 0; i < count; i++) begin
            sw = used_src_w();
            sh = used_src_h();
            if (i % 64 == 0) begin
                feed_steady = ($urandom_range(0, 3) == 0);
                sink_steady = ($urandom_range(0, 3) == 0);
            end
            kind = $urandom_range(0, 99);
            if (kind < 35 && sw != 0 && sh != 0)
                send_word(nssb_pkg::CMD_WRITE, 10'($urandom_range(0, sw - 1)),
                          9'($urandom_range(0, sh - 1)), 8'($urandom), 8'($urandom),
                          8'($urandom));
            else if (kind < 75 && cur_dst_w != 0 && cur_dst_h != 0)
                read_dst(10'($urandom_range(0, cur_dst_w - 1)),
                         9'($urandom_range(0, cur_dst_h - 1)));
            else if (kind < 85)
                read_dst(10'($urandom), 9'($urandom));
            else if (kind < 95)
                send_word(nssb_pkg::CMD_WRITE, 10'($urandom), 9'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom));
            else if (kind < 98)
                read_dst(10'(cur_dst_w), 9'($urandom));
            else
                send_word(nssb_pkg::CMD_WRITE, 10'($urandom), 9'(sh), 8'($urandom),
                          8'($urandom), 8'($urandom));
        end
        feed_steady = 1'b0;
        sink_steady = 1'b0;
    endtask

    // Identity mapping after reset: color extremes, truncation and range limits.
    task automatic test_reset_defaults();
        send_word(nssb_pkg::CMD_WRITE, 10'd0, 9'd0, 8'hFF, 8'hFF, 8'hFF);
        send_word(nssb_pkg::CMD_WRITE, 10'd319, 9'd239, 8'h00, 8'h00, 8'h00);
        send_word(nssb_pkg::CMD_WRITE, 10'd1, 9'd0, 8'hFF, 8'h00, 8'h00);
        send_word(nssb_pkg::CMD_WRITE, 10'd2, 9'd0, 8'h00, 8'hFF, 8'h00);
        send_word(nssb_pkg::CMD_WRITE, 10'd3, 9'd0, 8'h00, 8'h00, 8'hFF);
        send_word(nssb_pkg::CMD_WRITE, 10'd4, 9'd0, 8'h07, 8'h03, 8'h07);
        send_word(nssb_pkg::CMD_WRITE, 10'd0, 9'd1, 8'hAA, 8'h55, 8'hAA);
        // Outside the source: must not land on (0,1) or anywhere else.
        send_word(nssb_pkg::CMD_WRITE, 10'd320, 9'd0, 8'h12, 8'h34, 8'h56);
        send_word(nssb_pkg::CMD_WRITE, 10'd0, 9'd240, 8'h12, 8'h34, 8'h56);
        send_word(nssb_pkg::CMD_WRITE, 10'd1023, 9'd511, 8'hFF, 8'hFF, 8'hFF);
        send_word(nssb_pkg::CMD_WRITE, 10'd319, 9'd0, 8'h55, 8'hAA, 8'h55);
        read_dst(10'd0, 9'd0);
        read_dst(10'd319, 9'd239);
        read_dst(10'd1, 9'd0);
        read_dst(10'd2, 9'd0);
        read_dst(10'd3, 9'd0);
        read_dst(10'd4, 9'd0);
        read_dst(10'd0, 9'd1);
        read_dst(10'd319, 9'd0);
        // Outside the destination: no result word.
        read_dst(10'd320, 9'd0);
        read_dst(10'd0, 9'd240);
        read_dst(10'd1023, 9'd511);
    endtask

    // Upscaling from a single pixel and from a tiny source to the largest mode.
    task automatic test_upscale();
        set_sizes(9'd1, 8'd1, 10'd640, 9'd480);
        read_dst(10'd0, 9'd0);
        read_dst(10'd639, 9'd479);
        read_dst(10'd639, 9'd0);
        read_dst(10'd0, 9'd479);
        read_dst(10'd640, 9'd479);
        set_sizes(9'd3, 8'd2, 10'd640, 9'd480);
        random_items(60);
    endtask

    // Downscaling to a single pixel and to an odd small mode.
    task automatic test_downscale();
        set_sizes(9'd320, 8'd240, 10'd1, 9'd1);
        read_dst(10'd0, 9'd0);
        read_dst(10'd1, 9'd0);
        read_dst(10'd0, 9'd1);
        set_sizes(9'd320, 8'd240, 10'd13, 9'd7);
        random_items(60);
    endtask

    // Register values past the store are clamped; largest register values everywhere.
    task automatic test_size_clamp();
        set_sizes(9'd511, 8'd255, 10'd1023, 9'd511);
        send_word(nssb_pkg::CMD_WRITE, 10'd320, 9'd239, 8'hFF, 8'h00, 8'hFF);
        send_word(nssb_pkg::CMD_WRITE, 10'd319, 9'd240, 8'h00, 8'hFF, 8'h00);
        read_dst(10'd1022, 9'd510);
        read_dst(10'd0, 9'd0);
        read_dst(10'd1022, 9'd0);
        read_dst(10'd1023, 9'd510);
        random_items(80);
    endtask

    // A zero source size: reads give black, writes are dropped.
    task automatic test_empty_source();
        set_sizes(9'd0, 8'd240, 10'd640, 9'd480);
        random_items(40);
        set_sizes(9'd320, 8'd0, 10'd640, 9'd480);
        random_items(40);
    endtask

    // A zero destination size: reads give nothing at all.
    task automatic test_empty_dest();
        set_sizes(9'd320, 8'd240, 10'd0, 9'd480);
        random_items(40);
        set_sizes(9'd320, 8'd240, 10'd640, 9'd0);
        random_items(40);
    endtask

    // Receiver holds off for a long stretch while reads keep coming.
    task automatic test_output_stall();
        set_sizes(9'd8, 8'd8, 10'd640, 9'd480);
        hold_request = 1'b1;
        feed_steady  = 1'b1;
        for (int i = 0; i < 40; i++)
            read_dst(10'($urandom_range(0, 639)), 9'($urandom_range(0, 479)));
        feed_steady = 1'b0;
    endtask

    // Random sizes in turn until enough words have been sent.
    task automatic test_random_sizes();
        while (sent_items < TARGET_ITEMS) begin
            set_sizes(9'(pick_size(SRC_MAX_W, 511)), 8'(pick_size(SRC_MAX_H, 255)),
                      10'(pick_size(640, 1023)), 9'(pick_size(480, 511)));
            random_items(150);
        end
    endtask

    // Output ready: a random gap after each word, with an optional long hold.
    initial begin : sink_pacing
        bit took;
        int gap_left;
        int hold_left;
        m_axis_tready = 1'b0;
        gap_left  = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            took = (m_axis_tvalid === 1'b1) && m_axis_tready;
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (took)
                gap_left = sink_steady ? 0 : $urandom_range(0, 4);
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (gap_left != 0) begin
                gap_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each result word with the oldest expectation.
    initial begin : result_check
        t_pixel_word want;
        logic [15:0] got_rgb;
        logic [18:0] got_index;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready) begin
                got_rgb   = m_axis_tdata[15:0];
                got_index = m_axis_tdata[34:16];
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected word: expected none, actual rgb=%h index=%0d",
                             $time, got_rgb, got_index);
                    mismatch_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got_rgb !== want.rgb) begin
                        $display("%0t: rgb mismatch: expected %h, actual %h (index %0d)",
                                 $time, want.rgb, got_rgb, want.index);
                        mismatch_count++;
                    end
                    if (got_index !== want.index) begin
                        $display("%0t: index mismatch: expected %0d, actual %0d",
                                 $time, want.index, got_index);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = nssb_pkg::CFG_SRC_WIDTH;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = nssb_pkg::CMD_WRITE;
        mismatch_count = 0;
        sent_items     = 0;
        feed_steady    = 1'b0;
        sink_steady    = 1'b0;
        hold_request   = 1'b0;
        cur_src_w = nssb_pkg::RST_SRC_WIDTH;
        cur_src_h = nssb_pkg::RST_SRC_HEIGHT;
        cur_dst_w = nssb_pkg::RST_DST_WIDTH;
        cur_dst_h = nssb_pkg::RST_DST_HEIGHT;
        frame_written = '{default: 1'b0};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_upscale();
        test_downscale();
        test_size_clamp();
        test_empty_source();
        test_empty_dest();
        test_output_stall();
        test_random_sizes();

        settle_idle();
        if (mismatch_count == 0)
            $display("nearest_scale_rgb565_blit_core verification clean");
        else
            $display("nearest_scale_rgb565_blit_core verification failed");
        $finish;
    end

endmodule

### nearest_scale_rgb565_blit_core.f
rtl/nssb_pkg.sv
rtl/nssb_fifo.sv
rtl/nssb_front.sv
rtl/nssb_div.sv
rtl/nssb_back.sv
rtl/nearest_scale_rgb565_blit_core.sv
test/tb_top.sv
